[design/committed_range_set_unit_assert.svh]
// assertion macros for the range set checker
// expects clk_i and rst_ni in the scope of each use
`ifndef COMMITTED_RANGE_SET_UNIT_ASSERT_SVH
`define COMMITTED_RANGE_SET_UNIT_ASSERT_SVH

// same-cycle implication
`define CRS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CRS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/crs_pkg.sv]
// shared types and codes of the committed range set unit
// no dependencies
package crs_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam logic [ADDR_W-1:0] ADDR_LIMIT = '1;

  typedef enum logic [1:0] {
    OP_COMMIT  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TOTAL   = 2'd2,
    OP_WINDOW  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  // one range, hi is the exclusive end
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } span_t;

  typedef struct packed {
    logic pop;
    logic push;
  } chain_ctl_t;

endpackage

[design/committed_range_set_unit.sv]
// committed range set: sorted, coalesced table of address ranges held in a cell chain
// depends on crs_pkg and crs_chain
//
// use: drive opcode_i, range_start_i and range_size_i with start high; the request
// is taken at a clock edge where start is high and busy is low. Exactly one
// result follows: done_o is high for one cycle with committed_bytes_o and status_o.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// Zero-size and overflowing commits, releases and window queries answer from the
// idle state without touching the table. Every other request streams the n stored
// ranges once through the head of the chain, one range per cycle except where a
// commit inserts its own range or a release splits a range in two.
// With the table full, an update first makes a check pass over all ranges to
// decide whether it fits; a rejected update answers after that pass.
// The pace is set by the chain, which shifts a new range to its head on each pop.
// The next request can be given in the cycle done_o is high.
// Reset empties the table at once; no clearing pass is needed.
module committed_range_set_unit #(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode_i,
  input  logic [crs_pkg::ADDR_W-1:0] range_start_i,
  input  logic [crs_pkg::ADDR_W-1:0] range_size_i,
  output logic                       done_o,
  output logic [crs_pkg::ADDR_W-1:0] committed_bytes_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned AW    = crs_pkg::ADDR_W;
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_APPLY = 5'b00100,
    S_QUERY = 5'b01000,
    S_DRAIN = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  crs_pkg::opcode_e op_q, op_d;
  crs_pkg::span_t   cut_q, cut_d;
  crs_pkg::span_t   pend_q, pend_d;
  crs_pkg::span_t   qa_q, qa_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             split_q, split_d;
  logic             ins_q, ins_d;
  logic             flag_q, flag_d;
  logic             pend_vld_q, pend_vld_d;
  logic             qa_vld_q, qa_vld_d;
  logic [AW-1:0]    acc_q, acc_d;
  logic             done_q, done_d;
  logic [AW-1:0]    bytes_q, bytes_d;
  crs_pkg::status_e status_q, status_d;

  crs_pkg::chain_ctl_t ctl;
  crs_pkg::span_t      push_data;
  crs_pkg::span_t      head;
  logic [CNT_W-1:0]    push_idx;
  crs_pkg::opcode_e    op_in;
  logic [AW:0]         sum_w;
  logic                size_zero;

  assign op_in     = crs_pkg::opcode_e'(opcode_i);
  assign sum_w     = {1'b0, range_start_i} + {1'b0, range_size_i};
  assign size_zero = (range_size_i == '0);
  assign push_idx  = cnt_q - {{(CNT_W-1){1'b0}}, ctl.pop};

  crs_chain #(
    .DEPTH(MAX_RANGES),
    .IDX_W(CNT_W)
  ) u_chain (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .push_idx_i (push_idx),
    .push_data_i(push_data),
    .head_o     (head)
  );

  always_comb begin
    crs_pkg::span_t piece;
    logic           piece_v;
    piece      = head;
    piece_v    = 1'b0;
    ctl        = '0;
    push_data  = head;
    state_d    = state_q;
    op_d       = op_q;
    cut_d      = cut_q;
    pend_d     = pend_q;
    qa_d       = qa_q;
    rem_d      = rem_q;
    split_d    = split_q;
    ins_d      = ins_q;
    flag_d     = flag_q;
    pend_vld_d = pend_vld_q;
    qa_vld_d   = qa_vld_q;
    done_d     = 1'b0;
    bytes_d    = bytes_q;
    status_d   = status_q;
    acc_d      = acc_q;
    if (qa_vld_q && (qa_q.hi > qa_q.lo)) begin
      acc_d = acc_q + (qa_q.hi - qa_q.lo);
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (op_in)
            crs_pkg::OP_COMMIT, crs_pkg::OP_RELEASE: begin
              if (size_zero) begin
                done_d   = 1'b1;
                bytes_d  = '0;
                status_d = crs_pkg::ST_OK;
              end else if (sum_w[AW]) begin
                done_d   = 1'b1;
                bytes_d  = '0;
                status_d = crs_pkg::ST_OVF;
              end else begin
                op_d       = op_in;
                cut_d.lo   = range_start_i;
                cut_d.hi   = sum_w[AW-1:0];
                rem_d      = cnt_q;
                flag_d     = 1'b0;
                split_d    = 1'b0;
                ins_d      = 1'b0;
                pend_vld_d = 1'b0;
                state_d    = (cnt_q == CNT_W'(MAX_RANGES)) ? S_CHECK : S_APPLY;
              end
            end
            crs_pkg::OP_TOTAL: begin
              op_d     = op_in;
              cut_d.lo = '0;
              cut_d.hi = crs_pkg::ADDR_LIMIT;
              acc_d    = '0;
              rem_d    = cnt_q;
              qa_vld_d = 1'b0;
              state_d  = S_QUERY;
            end
            crs_pkg::OP_WINDOW: begin
              if (sum_w[AW]) begin
                done_d   = 1'b1;
                bytes_d  = '0;
                status_d = crs_pkg::ST_OVF;
              end else if (size_zero) begin
                done_d   = 1'b1;
                bytes_d  = '0;
                status_d = crs_pkg::ST_OK;
              end else begin
                op_d     = op_in;
                cut_d.lo = range_start_i;
                cut_d.hi = sum_w[AW-1:0];
                acc_d    = '0;
                rem_d    = cnt_q;
                qa_vld_d = 1'b0;
                state_d  = S_QUERY;
              end
            end
            default: ;
          endcase
        end
      end

      // full table: rotate once and find out whether the update grows the table
      S_CHECK: begin
        if (rem_q != '0) begin
          ctl.pop  = 1'b1;
          ctl.push = 1'b1;
          rem_d    = rem_q - 1'b1;
          if (op_q == crs_pkg::OP_COMMIT) begin
            flag_d = flag_q || ((head.lo <= cut_q.hi) && (head.hi >= cut_q.lo));
          end else begin
            flag_d = flag_q || ((head.lo < cut_q.lo) && (head.hi > cut_q.hi));
          end
        end else if ((op_q == crs_pkg::OP_COMMIT) ? !flag_q : flag_q) begin
          done_d   = 1'b1;
          bytes_d  = '0;
          status_d = crs_pkg::ST_FULL;
          state_d  = S_IDLE;
        end else begin
          rem_d   = cnt_q;
          state_d = S_APPLY;
        end
      end

      S_APPLY: begin
        if (op_q == crs_pkg::OP_RELEASE) begin
          if (rem_q != '0) begin
            if ((head.hi <= cut_q.lo) || (head.lo >= cut_q.hi)) begin
              ctl.pop  = 1'b1;
              ctl.push = 1'b1;
              rem_d    = rem_q - 1'b1;
            end else if ((head.lo < cut_q.lo) && !split_q && (head.hi > cut_q.hi)) begin
              // range split in two: prefix now, suffix next cycle
              ctl.push     = 1'b1;
              push_data.hi = cut_q.lo;
              split_d      = 1'b1;
            end else begin
              ctl.pop = 1'b1;
              rem_d   = rem_q - 1'b1;
              split_d = 1'b0;
              if (head.hi > cut_q.hi) begin
                ctl.push     = 1'b1;
                push_data.lo = cut_q.hi;
              end else if ((head.lo < cut_q.lo) && !split_q) begin
                ctl.push     = 1'b1;
                push_data.hi = cut_q.lo;
              end
            end
          end else begin
            done_d   = 1'b1;
            bytes_d  = '0;
            status_d = crs_pkg::ST_OK;
            state_d  = S_IDLE;
          end
        end else begin
          if (!ins_q && ((rem_q == '0) || (head.lo >= cut_q.lo))) begin
            piece   = cut_q;
            piece_v = 1'b1;
            ins_d   = 1'b1;
          end else if (rem_q != '0) begin
            piece   = head;
            piece_v = 1'b1;
            ctl.pop = 1'b1;
            rem_d   = rem_q - 1'b1;
          end else begin
            ctl.push  = pend_vld_q;
            push_data = pend_q;
            done_d    = 1'b1;
            bytes_d   = '0;
            status_d  = crs_pkg::ST_OK;
            state_d   = S_IDLE;
          end
          // union merge through the pending range
          if (piece_v) begin
            if (pend_vld_q && (pend_q.hi >= piece.lo)) begin
              if (piece.hi > pend_q.hi) begin
                pend_d.hi = piece.hi;
              end
            end else begin
              ctl.push   = pend_vld_q;
              push_data  = pend_q;
              pend_d     = piece;
              pend_vld_d = 1'b1;
            end
          end
        end
      end

      S_QUERY: begin
        if (rem_q != '0) begin
          ctl.pop  = 1'b1;
          ctl.push = 1'b1;
          rem_d    = rem_q - 1'b1;
          qa_d.lo  = (head.lo > cut_q.lo) ? head.lo : cut_q.lo;
          qa_d.hi  = (head.hi < cut_q.hi) ? head.hi : cut_q.hi;
          qa_vld_d = 1'b1;
        end else begin
          qa_vld_d = 1'b0;
          state_d  = S_DRAIN;
        end
      end

      S_DRAIN: begin
        done_d   = 1'b1;
        bytes_d  = acc_q;
        status_d = crs_pkg::ST_OK;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    cnt_d = cnt_q - {{(CNT_W-1){1'b0}}, ctl.pop} + {{(CNT_W-1){1'b0}}, ctl.push};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      rem_q      <= '0;
      split_q    <= 1'b0;
      ins_q      <= 1'b0;
      flag_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      qa_vld_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rem_q      <= rem_d;
      split_q    <= split_d;
      ins_q      <= ins_d;
      flag_q     <= flag_d;
      pend_vld_q <= pend_vld_d;
      qa_vld_q   <= qa_vld_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cut_q    <= cut_d;
    pend_q   <= pend_d;
    qa_q     <= qa_d;
    acc_q    <= acc_d;
    bytes_q  <= bytes_d;
    status_q <= status_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign committed_bytes_o = bytes_q;
  assign status_o          = status_q;

endmodule

[design/crs_cell.sv]
// one storage cell of the range chain
// depends on crs_pkg
module crs_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic          load_i,
  input  crs_pkg::span_t load_data_i,
  input  crs_pkg::span_t next_i,
  output crs_pkg::span_t data_o
);

  crs_pkg::span_t data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

[design/crs_chain.sv]
// row of range cells used as a queue: pop shifts toward the head, push loads one cell
// depends on crs_pkg and crs_cell
module crs_chain #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  crs_pkg::chain_ctl_t ctl_i,
  input  logic [IDX_W-1:0]    push_idx_i,
  input  crs_pkg::span_t      push_data_i,
  output crs_pkg::span_t      head_o
);

  crs_pkg::span_t cell_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    crs_pkg::span_t nbr_w;
    if (i == DEPTH - 1) begin : g_last
      assign nbr_w = cell_w[i];
    end else begin : g_mid
      assign nbr_w = cell_w[i+1];
    end
    crs_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ctl_i.pop),
      .load_i     (ctl_i.push && (push_idx_i == IDX_W'(i))),
      .load_data_i(push_data_i),
      .next_i     (nbr_w),
      .data_o     (cell_w[i])
    );
  end

  assign head_o = cell_w[0];

endmodule

[design/committed_range_set_unit_chk.sv]
// port-level checks of the committed range set unit, bound to the top level
// depends on crs_pkg and committed_range_set_unit_assert.svh
`include "committed_range_set_unit_assert.svh"

module committed_range_set_unit_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [crs_pkg::ADDR_W-1:0] committed_bytes_o,
  input logic [1:0]                 status_o
);

  // a taken request either answers at once or keeps the unit busy
  `CRS_ASSERT_NXT(a_start_ack, start && !busy, done_o || busy, "request neither answered nor busy")

  // leaving a table pass always delivers its result
  `CRS_ASSERT_IMP(a_busy_done, $fell(busy), done_o, "busy dropped without a result")

  // table full is only known after a pass over the table
  `CRS_ASSERT_IMP(a_full_pass, done_o && (status_o == crs_pkg::ST_FULL), $past(busy),
    "full status without a table pass")

  // error results carry no byte count
  `CRS_ASSERT_IMP(a_err_zero, done_o && (status_o != crs_pkg::ST_OK), committed_bytes_o == '0,
    "error result with nonzero bytes")

endmodule

bind committed_range_set_unit committed_range_set_unit_chk u_chk (.*);

[tb/committed_range_set_unit_tb.sv]
// self-checking bench for committed_range_set_unit: directed table, then random requests
// depends on crs_pkg and the committed_range_set_unit rtl
`timescale 1ns / 100ps

module committed_range_set_unit_tb;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam longint unsigned CYCLE_LIMIT = 1000000;
  localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0] bytes;
    logic [1:0]  status;
  } answer_t;

  typedef struct {
    crs_pkg::opcode_e op;
    logic [47:0]      base;
    logic [47:0]      len;
    bit               typed;
    answer_t          want;
  } stim_row_t;

  logic clk_i, rst_ni, start, busy, done_o;
  logic [1:0] opcode_i, status_o;
  logic [47:0] range_start_i, range_size_i, committed_bytes_o;

  // mirror of the range table
  logic [47:0] tab_lo[$];
  logic [47:0] tab_len[$];
  answer_t answer_q[$];
  bit failed;
  longint unsigned cycle_cnt;
  stim_row_t rows[$];

  committed_range_set_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .opcode_i(opcode_i), .range_start_i(range_start_i), .range_size_i(range_size_i),
    .done_o(done_o), .committed_bytes_o(committed_bytes_o), .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [1:0] update_ranges(logic [47:0] base, logic [47:0] len, bit rel);
    logic [47:0] lo_w[$];
    logic [47:0] len_w[$];
    logic [47:0] lo_m[$];
    logic [47:0] len_m[$];
    logic [48:0] fin, e;
    int j;
    fin = {1'b0, base} + len;
    for (int i = 0; i < tab_lo.size(); i++) begin
      e = {1'b0, tab_lo[i]} + tab_len[i];
      if (e <= base || tab_lo[i] >= fin) begin
        lo_w = {lo_w, tab_lo[i]}; len_w = {len_w, tab_len[i]};
      end else begin
        if (tab_lo[i] < base) begin
          lo_w = {lo_w, tab_lo[i]}; len_w = {len_w, 48'(base - tab_lo[i])};
        end
        if (e > fin) begin
          lo_w = {lo_w, fin[47:0]}; len_w = {len_w, 48'(e - fin)};
        end
      end
    end
    if (!rel) begin
      j = 0;
      while (j < lo_w.size() && lo_w[j] < base) j++;
      lo_w.insert(j, base); len_w.insert(j, len);
    end
    for (int i = 0; i < lo_w.size(); i++) begin
      if (lo_m.size() > 0 && lo_m[$] + len_m[$] == lo_w[i]) len_m[$] += len_w[i];
      else begin
        lo_m = {lo_m, lo_w[i]}; len_m = {len_m, len_w[i]};
      end
    end
    if (lo_m.size() > TABLE_DEPTH) return crs_pkg::ST_FULL;
    tab_lo = lo_m; tab_len = len_m;
    return crs_pkg::ST_OK;
  endfunction

  function automatic answer_t predict_answer(crs_pkg::opcode_e op, logic [47:0] base,
                                             logic [47:0] len);
    answer_t a;
    bit ovf;
    logic [47:0] fin, e, lo, hi;
    a = '0;
    ovf = len > (ALL_ONES - base);
    fin = base + len;
    case (op)
      crs_pkg::OP_COMMIT, crs_pkg::OP_RELEASE: begin
        if (len != 0) begin
          a.status = ovf ? crs_pkg::ST_OVF
                         : update_ranges(base, len, op == crs_pkg::OP_RELEASE);
        end
      end
      crs_pkg::OP_TOTAL: begin
        foreach (tab_len[i]) a.bytes += tab_len[i];
      end
      default: begin
        if (ovf) a.status = crs_pkg::ST_OVF;
        else if (len != 0) begin
          foreach (tab_lo[i]) begin
            e = tab_lo[i] + tab_len[i];
            lo = tab_lo[i] > base ? tab_lo[i] : base;
            hi = e < fin ? e : fin;
            if (hi > lo) a.bytes += hi - lo;
          end
        end
      end
    endcase
    return a;
  endfunction

  // start stays high after the request is taken; idling drops it
  task automatic send_request(crs_pkg::opcode_e op, logic [47:0] base, logic [47:0] len);
    opcode_i <= op; range_start_i <= base; range_size_i <= len; start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    answer_q = {answer_q, predict_answer(op, base, len)};
  endtask

  task automatic idle_burst(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        $error("committed_bytes: unexpected result %h", committed_bytes_o);
        failed = 1'b1;
      end else begin
        answer_t w;
        w = answer_q.pop_front();
        if (committed_bytes_o !== w.bytes) begin
          $error("committed_bytes: expected %h actual %h", w.bytes, committed_bytes_o);
          failed = 1'b1;
        end
        if (status_o !== w.status) begin
          $error("status: expected %h actual %h", w.status, status_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("committed_range_set_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [47:0] rand_addr(int mode);
    case (mode)
      0: return 48'({$urandom, $urandom} & 48'hFFF);
      1: return 48'({$urandom, $urandom});
      default: return ALL_ONES - 48'($urandom & 32'hFF);
    endcase
  endfunction

  function automatic void add_row(crs_pkg::opcode_e op, logic [47:0] b, logic [47:0] l, bit t,
                                  logic [47:0] wb, logic [1:0] ws);
    stim_row_t r;
    r.op = op; r.base = b; r.len = l; r.typed = t; r.want = {wb, ws};
    rows = {rows, r};
  endfunction

  initial begin
    crs_pkg::opcode_e op;
    logic [47:0] b, l;
    int ops;
    failed = 1'b0; cycle_cnt = 0;
    start = 1'b0; opcode_i = crs_pkg::OP_TOTAL; range_start_i = '0; range_size_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(crs_pkg::OP_TOTAL, 48'h0, 48'h0, 1, 48'h0, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_WINDOW, 48'h0, ALL_ONES, 1, 48'h0, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_WINDOW, 48'h1, ALL_ONES, 1, 48'h0, crs_pkg::ST_OVF);
    add_row(crs_pkg::OP_COMMIT, ALL_ONES, 48'h1, 1, 48'h0, crs_pkg::ST_OVF);
    add_row(crs_pkg::OP_RELEASE, ALL_ONES, ALL_ONES, 1, 48'h0, crs_pkg::ST_OVF);
    add_row(crs_pkg::OP_COMMIT, 48'h100, 48'h0, 1, 48'h0, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_COMMIT, 48'h100, 48'h100, 1, 48'h0, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_TOTAL, ALL_ONES, ALL_ONES, 1, 48'h100, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_COMMIT, 48'h200, 48'h80, 0, 0, 0);
    add_row(crs_pkg::OP_COMMIT, 48'h0, 48'h100, 0, 0, 0);
    add_row(crs_pkg::OP_RELEASE, 48'h180, 48'h10, 0, 0, 0);
    add_row(crs_pkg::OP_WINDOW, 48'h150, 48'h100, 0, 0, 0);
    add_row(crs_pkg::OP_WINDOW, 48'h150, 48'h0, 1, 48'h0, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_COMMIT, 48'h0, ALL_ONES, 1, 48'h0, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_TOTAL, 48'h0, 48'h0, 1, ALL_ONES, crs_pkg::ST_OK);
    add_row(crs_pkg::OP_RELEASE, 48'h1, ALL_ONES - 48'h1, 0, 0, 0);
    add_row(crs_pkg::OP_RELEASE, 48'h0, ALL_ONES, 0, 0, 0);
    for (int i = 0; i < TABLE_DEPTH + 1; i++) begin
      add_row(crs_pkg::OP_COMMIT, 48'(i * 4), 48'h2, 0, 0, 0);
    end
    add_row(crs_pkg::OP_WINDOW, 48'h0, ALL_ONES, 0, 0, 0);
    add_row(crs_pkg::OP_RELEASE, 48'h0, ALL_ONES, 0, 0, 0);

    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].base, rows[i].len);
      if (rows[i].typed && answer_q[$] !== rows[i].want) begin
        $error("directed row %0d: expected %h", i, rows[i].want);
        failed = 1'b1;
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      ops = $urandom_range(99);
      op = ops < 40 ? crs_pkg::OP_COMMIT : ops < 70 ? crs_pkg::OP_RELEASE :
           ops < 80 ? crs_pkg::OP_TOTAL : crs_pkg::OP_WINDOW;
      if ($urandom_range(99) < 85) begin
        b = 48'({$urandom, $urandom} & 48'h3FF);
        l = 48'($urandom_range(0, 40));
      end else begin
        b = rand_addr($urandom_range(0, 2));
        l = rand_addr($urandom_range(0, 2));
      end
      if ($urandom_range(99) < 4) begin
        b = 48'h0; l = 48'h0;
        repeat (3) begin
          send_request(crs_pkg::OP_RELEASE, b, ALL_ONES);
        end
      end
      send_request(op, b, l);
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk_i);
      end
      if (n < RANDOM_ITEMS - 60) idle_burst(30);
    end

    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed && answer_q.size() == 0) $display("committed_range_set_unit: match");
    else $display("committed_range_set_unit: mismatch");
    $finish;
  end

endmodule

[committed_range_set_unit.f]
+incdir+design
design/crs_pkg.sv
design/crs_cell.sv
design/crs_chain.sv
design/committed_range_set_unit.sv
design/committed_range_set_unit_chk.sv
tb/committed_range_set_unit_tb.sv
